[rtl/ccd_pkg.sv]
`timescale 1ns / 1ps
package ccd_pkg;

  localparam int COORD_BITS = 24;
  localparam int FRAC_BITS  = 8;
  localparam int LIMIT_W    = 23;
  localparam int SQ_W       = 2 * COORD_BITS;
  localparam int LSQ_W      = 2 * LIMIT_W;
  localparam int CMP_W      = (SQ_W > LSQ_W) ? SQ_W : LSQ_W;
  localparam int CFG_IDX_W  = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_MATCH = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_MOVE  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_STILL = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_SWING = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] CFG_CUT   = CFG_IDX_W'(4);

  localparam logic [LIMIT_W-1:0] MATCH_RST = LIMIT_W'(3 << FRAC_BITS);
  localparam logic [LIMIT_W-1:0] MOVE_RST  = LIMIT_W'(100 << FRAC_BITS);
  localparam logic [LIMIT_W-1:0] STILL_RST = LIMIT_W'(10 << FRAC_BITS);
  localparam logic [LIMIT_W-1:0] SWING_RST = LIMIT_W'(300 << FRAC_BITS);
  localparam logic [LIMIT_W-1:0] CUT_RST   = LIMIT_W'(50 << FRAC_BITS);

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic [SQ_W-1:0]              sq_t;
  typedef logic [LIMIT_W-1:0]           limit_t;
  typedef logic [LSQ_W-1:0]             limit_sq_t;

  typedef struct packed {
    coord_t eye_x;
    coord_t eye_y;
    coord_t eye_z;
    coord_t focus_x;
    coord_t focus_y;
    coord_t focus_z;
    logic   orthographic;
    logic   force_on;
    logic   force_skip;
  } ccd_in_t;

  typedef struct packed {
    logic interpolate;
    logic motion_cut;
  } ccd_out_t;

  typedef struct packed {
    logic ortho;
    logic force_on;
    logic force_skip;
  } ccd_flag_t;

  function automatic coord_t sat_wide(input logic signed [COORD_BITS:0] s);
    coord_t r;
    if (s[COORD_BITS] != s[COORD_BITS-1]) begin
      r = s[COORD_BITS] ? {1'b1, {(COORD_BITS-1){1'b0}}} : {1'b0, {(COORD_BITS-1){1'b1}}};
    end else begin
      r = s[COORD_BITS-1:0];
    end
    return r;
  endfunction

  function automatic coord_t sat_add(input coord_t a, input coord_t b);
    logic signed [COORD_BITS:0] s;
    s = {a[COORD_BITS-1], a} + {b[COORD_BITS-1], b};
    return sat_wide(s);
  endfunction

  function automatic coord_t sat_sub(input coord_t a, input coord_t b);
    logic signed [COORD_BITS:0] s;
    s = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
    return sat_wide(s);
  endfunction

  function automatic sq_t square(input coord_t a);
    logic [COORD_BITS-1:0] m;
    m = a[COORD_BITS-1] ? COORD_BITS'(~a + 1'b1) : COORD_BITS'(a);
    return SQ_W'(m) * SQ_W'(m);
  endfunction

endpackage

[rtl/camera_cut_detector.sv]
`timescale 1ns / 1ps
// throughput: one transaction per cycle while out_stall is low; input register,
// difference stage, square stage and decision stage each hold one item
// reset: synchronous active-low rst_n clears points, velocities, cut history and
// valid bits, and loads the limit registers with their default values
module camera_cut_detector (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  ccd_pkg::ccd_in_t              in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output ccd_pkg::ccd_out_t             out_data,
  input  logic                          cfg_we,
  input  logic [ccd_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [ccd_pkg::LIMIT_W-1:0]   cfg_wdata
);
  import ccd_pkg::*;

  // limits
  limit_t    match_r, move_r, still_r, swing_r, cut_r;
  limit_sq_t match_sq_r, move_sq_r, still_sq_r, swing_sq_r, cut_sq_r;

  // handshake
  logic ld0, ld1, ld2, ld_out;
  logic v0_r, v1_r, v2_r, vo_r;

  // camera state
  coord_t last_eye_r[3];
  coord_t last_foc_r[3];
  coord_t eye_spd_r[3];
  coord_t foc_spd_r[3];
  logic   last_cut_r;

  // input stage
  ccd_in_t s0_r;
  coord_t  eye_in[3];
  coord_t  foc_in[3];
  coord_t  pe[3];
  coord_t  pf[3];
  coord_t  e_miss_nxt[3];
  coord_t  f_miss_nxt[3];
  coord_t  e_vel_nxt[3];
  coord_t  f_vel_nxt[3];
  coord_t  mism_nxt[3];

  // difference stage
  coord_t    e_miss1_r[3];
  coord_t    f_miss1_r[3];
  coord_t    e_vel1_r[3];
  coord_t    f_vel1_r[3];
  coord_t    mism1_r[3];
  ccd_flag_t flags1_r;

  // square stage
  sq_t       e_miss2_r[3];
  sq_t       f_miss2_r[3];
  sq_t       e_vel2_r[3];
  sq_t       f_vel2_r[3];
  sq_t       mism2_r[3];
  ccd_flag_t flags2_r;

  // decision
  sq_t        e_d, f_d, v_d;
  logic [CMP_W-1:0] e_c, f_c, v_c;
  logic       c_carry, c_focus_still, c_eye_still, c_cut;
  logic       cut_nxt, interp_nxt;
  ccd_out_t   out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r <= MATCH_RST;
      move_r  <= MOVE_RST;
      still_r <= STILL_RST;
      swing_r <= SWING_RST;
      cut_r   <= CUT_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_MATCH: match_r <= cfg_wdata;
        CFG_MOVE:  move_r  <= cfg_wdata;
        CFG_STILL: still_r <= cfg_wdata;
        CFG_SWING: swing_r <= cfg_wdata;
        CFG_CUT:   cut_r   <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    match_sq_r <= LSQ_W'(match_r) * LSQ_W'(match_r);
    move_sq_r  <= LSQ_W'(move_r) * LSQ_W'(move_r);
    still_sq_r <= LSQ_W'(still_r) * LSQ_W'(still_r);
    swing_sq_r <= LSQ_W'(swing_r) * LSQ_W'(swing_r);
    cut_sq_r   <= LSQ_W'(cut_r) * LSQ_W'(cut_r);
  end

  assign ld_out   = !vo_r || !out_stall;
  assign ld2      = !v2_r || ld_out;
  assign ld1      = !v1_r || ld2;
  assign ld0      = !v0_r || ld1;
  assign in_stall = !ld0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      if (ld0) begin
        v0_r <= in_valid;
      end
      if (ld1) begin
        v1_r <= v0_r;
      end
      if (ld2) begin
        v2_r <= v1_r;
      end
      if (ld_out) begin
        vo_r <= v2_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld0) begin
      s0_r <= in_data;
    end
  end

  // predictions and misses; a cleared velocity turns each miss into the new velocity
  always_comb begin
    eye_in[0] = s0_r.eye_x;
    eye_in[1] = s0_r.eye_y;
    eye_in[2] = s0_r.eye_z;
    foc_in[0] = s0_r.focus_x;
    foc_in[1] = s0_r.focus_y;
    foc_in[2] = s0_r.focus_z;
    for (int i = 0; i < 3; i++) begin
      pe[i]         = sat_add(last_eye_r[i], eye_spd_r[i]);
      pf[i]         = sat_add(last_foc_r[i], foc_spd_r[i]);
      e_miss_nxt[i] = sat_sub(eye_in[i], pe[i]);
      f_miss_nxt[i] = sat_sub(foc_in[i], pf[i]);
      e_vel_nxt[i]  = sat_sub(eye_in[i], last_eye_r[i]);
      f_vel_nxt[i]  = sat_sub(foc_in[i], last_foc_r[i]);
      mism_nxt[i]   = sat_sub(e_vel_nxt[i], f_vel_nxt[i]);
    end
  end

  // speeds are kept uncleared; last_cut_r selects the cleared variant downstream
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        last_eye_r[i] <= '0;
        last_foc_r[i] <= '0;
        eye_spd_r[i]  <= '0;
        foc_spd_r[i]  <= '0;
      end
    end else if (v0_r && ld1 && !s0_r.orthographic) begin
      for (int i = 0; i < 3; i++) begin
        last_eye_r[i] <= eye_in[i];
        last_foc_r[i] <= foc_in[i];
        eye_spd_r[i]  <= e_vel_nxt[i];
        foc_spd_r[i]  <= f_vel_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld1) begin
      for (int i = 0; i < 3; i++) begin
        e_miss1_r[i] <= e_miss_nxt[i];
        f_miss1_r[i] <= f_miss_nxt[i];
        e_vel1_r[i]  <= e_vel_nxt[i];
        f_vel1_r[i]  <= f_vel_nxt[i];
        mism1_r[i]   <= mism_nxt[i];
      end
      flags1_r.ortho      <= s0_r.orthographic;
      flags1_r.force_on   <= s0_r.force_on;
      flags1_r.force_skip <= s0_r.force_skip;
    end
  end

  always_ff @(posedge clk) begin
    if (ld2) begin
      for (int i = 0; i < 3; i++) begin
        e_miss2_r[i] <= square(e_miss1_r[i]);
        f_miss2_r[i] <= square(f_miss1_r[i]);
        e_vel2_r[i]  <= square(e_vel1_r[i]);
        f_vel2_r[i]  <= square(f_vel1_r[i]);
        mism2_r[i]   <= square(mism1_r[i]);
      end
      flags2_r <= flags1_r;
    end
  end

  always_comb begin
    if (last_cut_r) begin
      e_d = e_vel2_r[0] + e_vel2_r[1] + e_vel2_r[2];
      f_d = f_vel2_r[0] + f_vel2_r[1] + f_vel2_r[2];
    end else begin
      e_d = e_miss2_r[0] + e_miss2_r[1] + e_miss2_r[2];
      f_d = f_miss2_r[0] + f_miss2_r[1] + f_miss2_r[2];
    end
    v_d = mism2_r[0] + mism2_r[1] + mism2_r[2];
    e_c = CMP_W'(e_d);
    f_c = CMP_W'(f_d);
    v_c = CMP_W'(v_d);

    c_carry       = (v_c <= CMP_W'(match_sq_r)) && (e_c <= CMP_W'(move_sq_r)) &&
                    (f_c <= CMP_W'(move_sq_r));
    c_focus_still = (f_c <= CMP_W'(still_sq_r)) && (e_c <= CMP_W'(swing_sq_r));
    c_eye_still   = (e_c <= CMP_W'(still_sq_r)) && (f_c <= CMP_W'(swing_sq_r));
    c_cut         = (v_c > CMP_W'(cut_sq_r)) || (f_c > CMP_W'(cut_sq_r)) ||
                    (e_c > CMP_W'(swing_sq_r));

    cut_nxt = !flags2_r.ortho && !(c_carry || c_focus_still || c_eye_still) && c_cut;

    if (flags2_r.force_skip) begin
      interp_nxt = 1'b0;
    end else if (flags2_r.force_on) begin
      interp_nxt = 1'b1;
    end else begin
      interp_nxt = !flags2_r.ortho && !cut_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_cut_r <= 1'b0;
    end else if (v2_r && ld_out && !flags2_r.ortho) begin
      last_cut_r <= cut_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_out) begin
      out_r.interpolate <= interp_nxt;
      out_r.motion_cut  <= cut_nxt;
    end
  end

  assign out_valid = vo_r;
  assign out_data  = out_r;

endmodule
